// ===== rtl/rect_clip_to_box_list_defines.svh =====
// ----------------------------------------------------------------------------
// rect_clip_to_box_list_defines
// assertion macros used by the clipper datapath
// ----------------------------------------------------------------------------
`ifndef RECT_CLIP_TO_BOX_LIST_DEFINES_SVH
`define RECT_CLIP_TO_BOX_LIST_DEFINES_SVH

// clocked property, held off during reset
`define RCBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define RCBL_ASSERT_NEVER(lbl, cond, msg) \
  `RCBL_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/rcbl_pkg.sv =====
// ----------------------------------------------------------------------------
// rcbl_pkg
// types and constants of the rectangle clipper
// ----------------------------------------------------------------------------
package rcbl_pkg;

  localparam int unsigned MAX_CLIP_BOXES_DEF = 16;
  localparam int unsigned CFG_IDX_W          = 1;
  localparam int unsigned CFG_DATA_W         = 16;

  localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [15:0] COORD_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_FILL   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 1'b0,
    REG_ORIGIN_Y = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        [1:0]  mode;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic        [15:0] rect_width;
    logic        [15:0] rect_height;
    logic signed [15:0] box_x1;
    logic signed [15:0] box_y1;
    logic signed [15:0] box_x2;
    logic signed [15:0] box_y2;
    logic               final_rect;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic        [15:0] major_count;
    logic        [15:0] minor_count;
    logic               box_valid;
    logic               last_of_run;
    logic               end_of_request;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
  } box_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic prep;     // clip rectangle to extent, rewind box index
    logic rd;       // read clip box at current index
    logic step;     // consume compare result, advance index
    logic finish;   // close out the rectangle
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic nonempty;
    logic hit;
    logic pend_valid;
    logic out_free;
    logic idx_last;
    logic final_rect;
  } dp_status_t;

endpackage

// ===== rtl/rcbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcbl_ctrl
// sequencer of the clipper: walks one rectangle over the clip list
// ----------------------------------------------------------------------------
module rcbl_ctrl import rcbl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHK,
    S_RD,
    S_CMP,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   fin_ok;
  logic   cmp_stall;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // a result needs the output register only when one is due
  assign fin_ok     = st_i.out_free || (!st_i.pend_valid && !st_i.final_rect);
  assign cmp_stall  = st_i.hit && st_i.pend_valid && !st_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (mode_i == MODE_FILL)) state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHK;
      end
      S_CHK: begin
        state_d = st_i.nonempty ? S_RD : S_FIN;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CMP;
      end
      S_CMP: begin
        if (!cmp_stall) begin
          cmd_o.step = 1'b1;
          state_d    = st_i.idx_last ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (fin_ok) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rcbl_dp.sv =====
// ----------------------------------------------------------------------------
// rcbl_dp
// clipper datapath: clip list memory, extent, intersection and output stage
// ----------------------------------------------------------------------------
`include "rect_clip_to_box_list_defines.svh"

module rcbl_dp import rcbl_pkg::*; #(
  parameter int unsigned MAX_CLIP_BOXES = MAX_CLIP_BOXES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_word_t              in_word_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            st_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o
);

  localparam int unsigned IDXW = (MAX_CLIP_BOXES > 1) ? $clog2(MAX_CLIP_BOXES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_CLIP_BOXES + 1);

  // configuration
  logic signed [15:0] origin_x_q, origin_y_q;

  // clip list
  box_t               mem [MAX_CLIP_BOXES];
  box_t               rd_q;
  logic [CNTW-1:0]    cnt_q;
  logic [IDXW-1:0]    idx_q;
  logic signed [15:0] ext_l_q, ext_t_q, ext_r_q, ext_b_q;

  // current rectangle
  logic signed [15:0] x_q, y_q;
  logic        [15:0] w_q, h_q;
  logic               final_q;
  logic signed [15:0] left_q, top_q;
  logic signed [17:0] right_q, bottom_q;

  // pending and output words
  logic      pend_valid_q;
  out_word_t pend_q;
  logic      out_valid_q;
  out_word_t out_q;

  logic       do_clear, do_append, do_fill;
  box_t       new_box;
  logic       out_free;

  always_comb begin
    do_clear  = 1'b0;
    do_append = 1'b0;
    do_fill   = 1'b0;
    case (in_word_i.mode)
      MODE_CLEAR:  do_clear  = cmd_i.accept;
      MODE_APPEND: do_append = cmd_i.accept && (cnt_q < CNTW'(MAX_CLIP_BOXES));
      MODE_FILL:   do_fill   = cmd_i.accept;
      default: ;
    endcase
  end

  assign new_box = '{x1: in_word_i.box_x1, y1: in_word_i.box_y1,
                     x2: in_word_i.box_x2, y2: in_word_i.box_y2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: origin_x_q <= cfg_data_i;
        REG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_append) mem[cnt_q[IDXW-1:0]] <= new_box;
    if (cmd_i.rd)  rd_q <= mem[idx_q];
  end

  // list count and bounding extent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ext_l_q <= COORD_MAX;
      ext_t_q <= COORD_MAX;
      ext_r_q <= COORD_MIN;
      ext_b_q <= COORD_MIN;
    end else if (do_clear) begin
      cnt_q   <= '0;
      ext_l_q <= COORD_MAX;
      ext_t_q <= COORD_MAX;
      ext_r_q <= COORD_MIN;
      ext_b_q <= COORD_MIN;
    end else if (do_append) begin
      cnt_q <= cnt_q + CNTW'(1);
      if (new_box.x1 < ext_l_q) ext_l_q <= new_box.x1;
      if (new_box.y1 < ext_t_q) ext_t_q <= new_box.y1;
      if (new_box.x2 > ext_r_q) ext_r_q <= new_box.x2;
      if (new_box.y2 > ext_b_q) ext_b_q <= new_box.y2;
    end
  end

  // translate by origin, wrapping to 16 bits
  always_ff @(posedge clk_i) begin
    if (do_fill) begin
      x_q     <= in_word_i.rect_x + origin_x_q;
      y_q     <= in_word_i.rect_y + origin_y_q;
      w_q     <= in_word_i.rect_width;
      h_q     <= in_word_i.rect_height;
      final_q <= in_word_i.final_rect;
    end
  end

  // far edges at full precision, then clip to extent
  logic signed [17:0] r_full, b_full, ext_r18, ext_b18;
  assign r_full  = $signed({{2{x_q[15]}}, x_q} + {2'b00, w_q});
  assign b_full  = $signed({{2{y_q[15]}}, y_q} + {2'b00, h_q});
  assign ext_r18 = $signed({{2{ext_r_q[15]}}, ext_r_q});
  assign ext_b18 = $signed({{2{ext_b_q[15]}}, ext_b_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      left_q   <= (x_q > ext_l_q) ? x_q : ext_l_q;
      top_q    <= (y_q > ext_t_q) ? y_q : ext_t_q;
      right_q  <= (r_full < ext_r18) ? r_full : ext_r18;
      bottom_q <= (b_full < ext_b18) ? b_full : ext_b18;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.prep) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IDXW'(1);
    end
  end

  logic signed [17:0] left18, top18;
  assign left18 = $signed({{2{left_q[15]}}, left_q});
  assign top18  = $signed({{2{top_q[15]}}, top_q});

  // intersection with the box just read
  logic signed [15:0] bx1, by1, ix1, iy1, ix2, iy2;
  logic signed [17:0] bx2_18, by2_18, ix2_18, iy2_18;
  logic        [15:0] maj, mnr;
  logic               hit;
  out_word_t          hit_word;

  assign bx1    = rd_q.x1;
  assign by1    = rd_q.y1;
  assign bx2_18 = $signed({{2{rd_q.x2[15]}}, rd_q.x2});
  assign by2_18 = $signed({{2{rd_q.y2[15]}}, rd_q.y2});
  assign ix1    = (left_q > bx1) ? left_q : bx1;
  assign iy1    = (top_q > by1) ? top_q : by1;
  assign ix2_18 = (right_q < bx2_18) ? right_q : bx2_18;
  assign iy2_18 = (bottom_q < by2_18) ? bottom_q : by2_18;
  assign ix2    = ix2_18[15:0];
  assign iy2    = iy2_18[15:0];
  assign hit    = (ix1 < ix2) && (iy1 < iy2);
  assign maj    = ix2 - ix1 - 16'sd1;
  assign mnr    = iy2 - iy1 - 16'sd1;

  assign hit_word = '{dest_x: ix1, dest_y: iy1, major_count: maj, minor_count: mnr,
                      box_valid: 1'b1, last_of_run: 1'b0, end_of_request: 1'b0};

  // words into the output register
  logic      push_en;
  out_word_t push_word;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    push_en   = 1'b0;
    push_word = pend_q;
    if (cmd_i.step && hit && pend_valid_q) begin
      push_en = 1'b1;
    end else if (cmd_i.finish && pend_valid_q) begin
      push_en                  = 1'b1;
      push_word.last_of_run    = 1'b1;
      push_word.end_of_request = final_q;
    end else if (cmd_i.finish && final_q) begin
      push_en                  = 1'b1;
      push_word                = '0;
      push_word.last_of_run    = 1'b1;
      push_word.end_of_request = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.step && hit) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.finish) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && hit) pend_q <= hit_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) out_q <= push_word;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign st_o.nonempty   = (left18 < right_q) && (top18 < bottom_q);
  assign st_o.hit        = hit;
  assign st_o.pend_valid = pend_valid_q;
  assign st_o.out_free   = out_free;
  assign st_o.idx_last   = ((CNTW'(idx_q) + CNTW'(1)) == cnt_q);
  assign st_o.final_rect = final_q;

  `RCBL_ASSERT_NEVER(a_cnt_range, cnt_q > CNTW'(MAX_CLIP_BOXES), "clip count past capacity")
  `RCBL_ASSERT(a_push_free, push_en |-> out_free, "output word overwritten")
  `RCBL_ASSERT(a_pend_hold, (pend_valid_q && !cmd_i.step && !cmd_i.finish) |=> pend_valid_q, "pending word lost")
  `RCBL_ASSERT(a_marker, (cmd_i.finish && !pend_valid_q && final_q) |=> (out_valid_q && !out_q.box_valid && out_q.end_of_request), "end marker missing")

endmodule

// ===== rtl/rect_clip_to_box_list.sv =====
// clear and append words are handled without leaving idle; a fill word holds the input after it is taken,
// through prep and check, then one read and one compare per stored box, then finish
// a fill that misses the list extent holds the input through prep, check and finish only
// results are held in a pending word, then pass through a registered output stage
// a stalled output holds the box walk when a second result is due, and holds the finish step when a word is due
// reset clears the list count, extent, origins and all control; the box memory is not cleared
// ----------------------------------------------------------------------------
// rect_clip_to_box_list
// clips fill rectangles against a stored list of clip boxes into fill commands
// ----------------------------------------------------------------------------
module rect_clip_to_box_list import rcbl_pkg::*; #(
  parameter int unsigned MAX_CLIP_BOXES = MAX_CLIP_BOXES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input words: clear, append or fill
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o
);

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t st;

  // sequencer: idle, prep, check, then read and compare per box, finish
  rcbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (in_word_i.mode),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath: clip list memory, extent tracking, intersection, one pending
  // word so the last result of a rectangle can be flagged, output register
  rcbl_dp #(
    .MAX_CLIP_BOXES (MAX_CLIP_BOXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
